### src/cssc_pkg.sv
package cssc_pkg;

   localparam int CHANNEL_COUNT = 144;
   localparam int STRIP_COUNT   = 5;
   localparam int CH_AW         = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int REG_COUNT     = 8;
   localparam int MAX_CLEARS    = 4;

   localparam int CC_SHIFT      = 22;
   localparam int COMP_RECIP    = ((1 << CC_SHIFT) + 119) / 120;
   localparam int GATE_RECIP    = ((1 << CC_SHIFT) + 159) / 160;

   typedef enum logic [2:0] {
      OP_FADER  = 3'd0,
      OP_ROTATE = 3'd1,
      OP_CLICK  = 3'd2,
      OP_DOUBLE = 3'd3,
      OP_MUTE   = 3'd4,
      OP_SOLO   = 3'd5,
      OP_SELECT = 3'd6,
      OP_DYN    = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_CC      = 3'd1,
      KIND_NOTE_ON = 3'd2,
      KIND_NOTE_OFF= 3'd3,
      KIND_CLEARED = 3'd4
   } kind_type;

   localparam logic [1:0] MODE_COMP = 2'd0;
   localparam logic [1:0] MODE_GATE = 2'd1;
   localparam logic [1:0] MODE_PAN  = 2'd2;

   localparam logic [2:0] REG_FADER_CC = 3'd0;
   localparam logic [2:0] REG_COMP_CC  = 3'd1;
   localparam logic [2:0] REG_GATE_CC  = 3'd2;
   localparam logic [2:0] REG_PAN_CC   = 3'd3;
   localparam logic [2:0] REG_MUTE_NB  = 3'd4;
   localparam logic [2:0] REG_SOLO_NB  = 3'd5;
   localparam logic [2:0] REG_SEL_NB   = 3'd6;
   localparam logic [2:0] REG_DYN_NB   = 3'd7;

   typedef struct packed {
      logic [6:0]        fader;
      logic              mute;
      logic              solo;
      logic              sel;
      logic              dyn;
      logic signed [7:0] comp;
      logic signed [8:0] gate;
      logic signed [6:0] pan;
      logic [1:0]        mode;
   } chan_rec_type;

   localparam chan_rec_type RESET_REC = '{
      fader: 7'd100, mute: 1'b0, solo: 1'b0, sel: 1'b0, dyn: 1'b1,
      comp: -8'sd40, gate: -9'sd80, pan: 7'sd0, mode: MODE_COMP};

   function automatic logic [7:0] start_chan(input int i);
      logic [7:0] r;
      case (i)
         0:       r = 8'd1;
         1:       r = 8'd8;
         2:       r = 8'd15;
         3:       r = 8'd23;
         4:       r = 8'd32;
         default: r = 8'd1;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] chan_num(input logic [7:0] c);
      logic [7:0] r;
      if (c < 8'd1 || 32'(c) > CHANNEL_COUNT) r = 8'd1;
      else r = c;
      return r;
   endfunction

   function automatic logic [CH_AW-1:0] chan_index(input logic [7:0] c);
      logic [7:0] n;
      n = chan_num(c) - 8'd1;
      return n[CH_AW-1:0];
   endfunction

endpackage

### src/control_surface_strip_controller.sv
// A simple event reads its channel record, executes and then registers its result beat; a
// compressor or gate rotate adds a step that scales the CC value, and a click that turns the
// page reads the new channel's record again. Select first scans each other strip and clears
// its select bit, reporting up to four clears, before the note result. One event is processed
// at a time and the next input beat is taken only after the last result beat is accepted.
// Synchronous reset restores strips, registers and valid bits; unwritten channels read as reset.
module control_surface_strip_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // strip_index, fader_value, rotate_delta
   input  logic [2:0]  req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // report_strip, channel_number, message_number,
                                   // message_data, parameter_value, encoder_mode, page_mode,
                                   // page_target, current_channel, button_state
   output logic [2:0]  rsp_tuser,  // message_kind
   output logic        rsp_tlast,  // last_result
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_data
);
   import cssc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_SCAN_LOAD, ST_RD, ST_LOAD, ST_EXEC, ST_CCV, ST_EMIT, ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [2:0]        sidx_ff, sidx_in, ptr_ff, ptr_in, nclr_ff, nclr_in;
   logic [6:0]        fv_ff, fv_in;
   logic signed [6:0] d_ff, d_in;
   logic              reread_ff, reread_in;
   chan_rec_type      rec_ff, rec_in, ld;
   logic [CH_AW-1:0]  cidx_ff, cidx_in, rd_addr;
   kind_type          kind_ff, kind_in;
   logic [6:0]        num_ff, num_in, data_ff, data_in;
   logic signed [8:0] param_ff, param_in;
   logic              btn_ff, btn_in, last_ff, last_in;
   logic [7:0]        ccu_ff, ccu_in;
   logic              ccgate_ff, ccgate_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [55:0]       rsp_data_ff, rsp_data_in;
   logic [7:0]        strip_ch_ff [STRIP_COUNT];
   logic              strip_pm_ff [STRIP_COUNT];
   logic [7:0]        strip_tg_ff [STRIP_COUNT];
   logic [7:0]        sch_in, stg_in;
   logic              spm_in, strip_we;
   logic [6:0]        cfg_ff [REG_COUNT];
   logic              valid_ff [CHANNEL_COUNT];
   chan_rec_type      mem [CHANNEL_COUNT];
   chan_rec_type      mem_q_ff, wr_data;
   logic              mem_v_ff, rd_en, wr_en;
   logic [14:0]       ccx;
   logic [31:0]       ccp;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   assign rd_addr = chan_index(strip_ch_ff[ptr_ff]);
   assign ld      = mem_v_ff ? mem_q_ff : RESET_REC;
   assign ccx     = {ccu_ff, 7'd0} - {7'd0, ccu_ff};
   assign ccp     = 32'(ccx) * (ccgate_ff ? 32'(GATE_RECIP) : 32'(COMP_RECIP));

   always_comb begin
      logic signed [9:0] t;
      logic [2:0]        s;
      chan_rec_type      r;
      logic [7:0]        cn;
      logic              adv;

      state_in = state_ff; op_in = op_ff; sidx_in = sidx_ff; ptr_in = ptr_ff;
      nclr_in = nclr_ff; fv_in = fv_ff; d_in = d_ff; reread_in = reread_ff;
      rec_in = rec_ff; cidx_in = cidx_ff; kind_in = kind_ff; num_in = num_ff;
      data_in = data_ff; param_in = param_ff; btn_in = btn_ff; last_in = last_ff;
      ccu_in = ccu_ff; ccgate_in = ccgate_ff; rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      sch_in = strip_ch_ff[ptr_ff]; spm_in = strip_pm_ff[ptr_ff];
      stg_in = strip_tg_ff[ptr_ff]; strip_we = 1'b0;
      rd_en = 1'b0; wr_en = 1'b0; wr_data = rec_ff;
      t = '0; s = '0; r = rec_ff; cn = '0; adv = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               s = req_tdata[2:0];
               if (32'(s) >= STRIP_COUNT) s = 3'd0;
               op_in = op_type'(req_tuser);
               sidx_in = s;
               fv_in = req_tdata[9:3];
               d_in = req_tdata[16:10];
               nclr_in = 3'd0;
               reread_in = 1'b0;
               if (op_type'(req_tuser) == OP_SELECT) begin
                  ptr_in = 3'd0;
                  state_in = ST_SCAN;
               end else begin
                  ptr_in = s;
                  state_in = ST_RD;
               end
            end
         end
         ST_SCAN: begin
            if (ptr_ff == sidx_ff) begin
               adv = 1'b1;
            end else begin
               rd_en = 1'b1;
               cidx_in = rd_addr;
               state_in = ST_SCAN_LOAD;
            end
         end
         ST_SCAN_LOAD: begin
            r = ld;
            r.sel = 1'b0;
            rec_in = r;
            if (ld.sel) begin
               wr_en = 1'b1;
               wr_data = r;
               if (32'(nclr_ff) < MAX_CLEARS) begin
                  nclr_in = nclr_ff + 3'd1;
                  kind_in = KIND_CLEARED;
                  num_in = '0; data_in = '0; param_in = '0; btn_in = 1'b0;
                  last_in = 1'b0;
                  state_in = ST_EMIT;
               end else begin
                  adv = 1'b1;
               end
            end else begin
               adv = 1'b1;
            end
         end
         ST_RD: begin
            rd_en = 1'b1;
            cidx_in = rd_addr;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rec_in = ld;
            state_in = reread_ff ? ST_EMIT : ST_EXEC;
         end
         ST_EXEC: begin
            r = rec_ff;
            kind_in = KIND_NONE;
            num_in = '0; data_in = '0; param_in = '0; btn_in = 1'b0;
            last_in = 1'b1;
            state_in = ST_EMIT;
            cn = 8'(cidx_ff);
            case (op_ff)
               OP_FADER: begin
                  r.fader = fv_ff;
                  kind_in = KIND_CC;
                  num_in = cfg_ff[REG_FADER_CC];
                  data_in = fv_ff;
                  param_in = 9'(signed'({2'b0, fv_ff}));
               end
               OP_ROTATE: begin
                  if (strip_pm_ff[ptr_ff]) begin
                     t = 10'(signed'({2'b0, strip_tg_ff[ptr_ff]})) + 10'(d_ff);
                     if (t < 10'sd1) t = 10'sd1;
                     if (t > 10'(CHANNEL_COUNT)) t = 10'(CHANNEL_COUNT);
                     stg_in = t[7:0];
                     strip_we = 1'b1;
                  end else if (rec_ff.mode == MODE_COMP) begin
                     t = 10'(rec_ff.comp) + 10'(d_ff);
                     if (t < -10'sd120) t = -10'sd120;
                     if (t > 10'sd0) t = 10'sd0;
                     r.comp = t[7:0];
                     kind_in = KIND_CC;
                     num_in = cfg_ff[REG_COMP_CC];
                     param_in = t[8:0];
                     ccu_in = 8'(t + 10'sd120);
                     ccgate_in = 1'b0;
                     state_in = ST_CCV;
                  end else if (rec_ff.mode == MODE_GATE) begin
                     t = 10'(rec_ff.gate) + 10'(d_ff);
                     if (t < -10'sd160) t = -10'sd160;
                     if (t > 10'sd0) t = 10'sd0;
                     r.gate = t[8:0];
                     kind_in = KIND_CC;
                     num_in = cfg_ff[REG_GATE_CC];
                     param_in = t[8:0];
                     ccu_in = 8'(t + 10'sd160);
                     ccgate_in = 1'b1;
                     state_in = ST_CCV;
                  end else begin
                     t = 10'(rec_ff.pan) + 10'(d_ff);
                     if (t < -10'sd63) t = -10'sd63;
                     if (t > 10'sd63) t = 10'sd63;
                     r.pan = t[6:0];
                     kind_in = KIND_CC;
                     num_in = cfg_ff[REG_PAN_CC];
                     data_in = 7'(t + 10'sd64);
                     param_in = t[8:0];
                  end
               end
               OP_CLICK: begin
                  if (strip_pm_ff[ptr_ff]) begin
                     sch_in = strip_tg_ff[ptr_ff];
                     spm_in = 1'b0;
                     strip_we = 1'b1;
                     reread_in = 1'b1;
                     state_in = ST_RD;
                  end else begin
                     case (rec_ff.mode)
                        MODE_COMP: r.mode = MODE_GATE;
                        MODE_GATE: r.mode = MODE_PAN;
                        MODE_PAN:  r.mode = MODE_COMP;
                        default:   r.mode = MODE_GATE;
                     endcase
                  end
               end
               OP_DOUBLE: begin
                  strip_we = 1'b1;
                  if (strip_pm_ff[ptr_ff]) begin
                     spm_in = 1'b0;
                  end else begin
                     spm_in = 1'b1;
                     stg_in = strip_ch_ff[ptr_ff];
                  end
               end
               default: begin
                  case (op_ff)
                     OP_MUTE: begin
                        r.mute = !rec_ff.mute; btn_in = r.mute;
                        num_in = cfg_ff[REG_MUTE_NB] + cn[6:0];
                     end
                     OP_SOLO: begin
                        r.solo = !rec_ff.solo; btn_in = r.solo;
                        num_in = cfg_ff[REG_SOLO_NB] + cn[6:0];
                     end
                     OP_SELECT: begin
                        r.sel = !rec_ff.sel; btn_in = r.sel;
                        num_in = cfg_ff[REG_SEL_NB] + cn[6:0];
                     end
                     default: begin
                        r.dyn = !rec_ff.dyn; btn_in = r.dyn;
                        num_in = cfg_ff[REG_DYN_NB] + cn[6:0];
                     end
                  endcase
                  kind_in = btn_in ? KIND_NOTE_ON : KIND_NOTE_OFF;
               end
            endcase
            rec_in = r;
            wr_en = 1'b1;
            wr_data = r;
         end
         ST_CCV: begin
            data_in = ccp[CC_SHIFT +: 7];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_data_in = {2'b0, btn_ff, strip_ch_ff[ptr_ff], strip_tg_ff[ptr_ff],
                           strip_pm_ff[ptr_ff], rec_ff.mode, param_ff, data_ff, num_ff,
                           chan_num(strip_ch_ff[ptr_ff]), ptr_ff};
            rsp_valid_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) state_in = ST_IDLE;
               else adv = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (adv) begin
         if (32'(ptr_ff) >= STRIP_COUNT - 1) begin
            ptr_in = sidx_ff;
            state_in = ST_RD;
         end else begin
            ptr_in = ptr_ff + 3'd1;
            state_in = ST_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STRIP_COUNT; i++) begin
            strip_ch_ff[i] <= start_chan(i);
            strip_tg_ff[i] <= start_chan(i);
            strip_pm_ff[i] <= 1'b0;
         end
         cfg_ff[REG_FADER_CC] <= 7'd7;
         cfg_ff[REG_COMP_CC]  <= 7'd20;
         cfg_ff[REG_GATE_CC]  <= 7'd21;
         cfg_ff[REG_PAN_CC]   <= 7'd10;
         cfg_ff[REG_MUTE_NB]  <= 7'd0;
         cfg_ff[REG_SOLO_NB]  <= 7'd32;
         cfg_ff[REG_SEL_NB]   <= 7'd64;
         cfg_ff[REG_DYN_NB]   <= 7'd96;
         for (int i = 0; i < CHANNEL_COUNT; i++) valid_ff[i] <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (strip_we) begin
            strip_ch_ff[ptr_ff] <= sch_in;
            strip_tg_ff[ptr_ff] <= stg_in;
            strip_pm_ff[ptr_ff] <= spm_in;
         end
         if (csr_valid) cfg_ff[csr_index] <= csr_data;
         if (wr_en) valid_ff[cidx_ff] <= 1'b1;
      end
      op_ff <= op_in; sidx_ff <= sidx_in; ptr_ff <= ptr_in; nclr_ff <= nclr_in;
      fv_ff <= fv_in; d_ff <= d_in; reread_ff <= reread_in; rec_ff <= rec_in;
      cidx_ff <= cidx_in; kind_ff <= kind_in; num_ff <= num_in; data_ff <= data_in;
      param_ff <= param_in; btn_ff <= btn_in; last_ff <= last_in; ccu_ff <= ccu_in;
      ccgate_ff <= ccgate_in; rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[cidx_ff] <= wr_data;
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         mem_v_ff <= valid_ff[rd_addr];
      end
   end

endmodule

### src/cssc_checker.sv
module cssc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import cssc_pkg::*;

   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while a result waits");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("second beat taken at once");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_NONE || rsp_tuser == KIND_CC ||
                      rsp_tuser == KIND_NOTE_ON || rsp_tuser == KIND_NOTE_OFF ||
                      rsp_tuser == KIND_CLEARED)) else $error("bad message kind");

   a_clear_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_CLEARED) |-> !rsp_tlast)
      else $error("clear report marked last");

endmodule

bind control_surface_strip_controller cssc_checker u_cssc_checker (.*);
